// ----- sv/dpss_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive power state sequencer package
// Types, state codes, status masks and control words shared by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dpss_pkg;

   localparam int AXIS_W   = 3;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 16;
   localparam int POS_W    = 32;
   localparam int COUNT_W  = 3;
   localparam int CTRL_W   = 8;
   localparam int CW_W     = 16;

   typedef enum logic [2:0] {
      ST_NOT_READY      = 3'd0,
      ST_SWON_DIS       = 3'd1,
      ST_READY          = 3'd2,
      ST_SWITCHED_ON    = 3'd3,
      ST_OP_ENABLED     = 3'd4,
      ST_FAULT_REACTION = 3'd5,
      ST_MALFUNCTION    = 3'd6
   } drive_state_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_STATUS = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REPORT_IDLE      = 2'd0,
      REPORT_OPERATING = 2'd1,
      REPORT_FAULT     = 2'd2
   } report_type;

   // control words
   localparam logic [CTRL_W-1:0] CW_SHUTDOWN    = 8'h06;
   localparam logic [CTRL_W-1:0] CW_SWITCH_ON   = 8'h07;
   localparam logic [CTRL_W-1:0] CW_ENABLE_OP   = 8'h0F;
   localparam logic [CTRL_W-1:0] CW_FAULT_RESET = 8'h80;

   // status word masks and patterns (low byte)
   localparam logic [7:0] MASK_4F = 8'h4F;
   localparam logic [7:0] MASK_69 = 8'h69;
   localparam logic [7:0] MASK_6F = 8'h6F;
   localparam logic [7:0] MASK_7F = 8'h7F;

   localparam logic [7:0] SW_NONE        = 8'h00;
   localparam logic [7:0] SW_ON_DISABLED = 8'h40;
   localparam logic [7:0] SW_RDY_ONLY    = 8'h01;
   localparam logic [7:0] SW_READY_QS    = 8'h21;
   localparam logic [7:0] SW_ON_QS       = 8'h23;
   localparam logic [7:0] SW_OPERATING   = 8'h37;

   localparam int SW_BIT_READY = 0;
   localparam int SW_BIT_FAULT = 3;

   typedef struct packed {
      drive_state_type   state;
      cmd_type           cmd;
      logic [CTRL_W-1:0] ctrl;
      report_type        report;
   } axis_state_type;

endpackage

`default_nettype wire

// ----- sv/dpss_if.sv -----
// ----------------------------------------------------------------------------
// Drive power state sequencer channels
// Valid/ready channels for requests, responses and the axis count register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dpss_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [dpss_pkg::AXIS_W-1:0]          axis;
   logic [dpss_pkg::OP_W-1:0]            operation;
   logic [dpss_pkg::STATUS_W-1:0]        status_word;
   logic signed [dpss_pkg::POS_W-1:0]    actual_position;

   modport source (output valid, axis, operation, status_word, actual_position,
                   input ready);
   modport sink   (input valid, axis, operation, status_word, actual_position,
                   output ready);
endinterface

interface dpss_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 accepted;
   logic [dpss_pkg::CW_W-1:0]            control_word;
   logic [2:0]                           drive_state;
   logic [1:0]                           axis_report;
   logic                                 target_valid;
   logic signed [dpss_pkg::POS_W-1:0]    target_position;

   modport source (output valid, accepted, control_word, drive_state, axis_report,
                   target_valid, target_position, input ready);
   modport sink   (input valid, accepted, control_word, drive_state, axis_report,
                   target_valid, target_position, output ready);
endinterface

interface dpss_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dpss_pkg::COUNT_W-1:0]         axis_count;

   modport source (output valid, axis_count, input ready);
   modport sink   (input valid, axis_count, output ready);
endinterface

`default_nettype wire

// ----- sv/drive_power_state_sequencer.sv -----
// ----------------------------------------------------------------------------
// Drive power state sequencer
// Per-axis CiA 402 style power-up sequencing of servo drives.
//
//   channel   dir   payload
//   req_ch    in    axis, operation, status_word, actual_position
//   rsp_ch    out   accepted, control_word, drive_state, axis_report,
//                   target_valid, target_position
//   csr_ch    in    axis_count (always ready)
//
// One request per cycle unless the response stalls; a request passes the
// input register, then the result register, before its response is valid.
// Axis state lives in flops updated at the same edge that loads the result,
// so back-to-back requests on one axis see the previous update. Reset clears
// all axis state at once. A stalled response holds the request register;
// input stalls only when both stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drive_power_state_sequencer #(
   parameter int NUM_AXES = 6
) (
   input  logic            clock,
   input  logic            reset,
   dpss_req_if.sink        req_ch,
   dpss_rsp_if.source      rsp_ch,
   dpss_csr_if.sink        csr_ch
);

   logic [dpss_pkg::COUNT_W-1:0]        axis_count_ff;

   logic                                in_vld_ff;
   logic [dpss_pkg::AXIS_W-1:0]         in_axis_ff;
   logic [dpss_pkg::OP_W-1:0]           in_op_ff;
   logic [dpss_pkg::STATUS_W-1:0]       in_sw_ff;
   logic signed [dpss_pkg::POS_W-1:0]   in_pos_ff;

   dpss_pkg::axis_state_type            axis_ff [NUM_AXES];

   logic                                rsp_vld_ff;
   logic                                rsp_acc_ff;
   logic [dpss_pkg::CTRL_W-1:0]         rsp_ctrl_ff;
   dpss_pkg::drive_state_type           rsp_state_ff;
   dpss_pkg::report_type                rsp_report_ff;
   logic                                rsp_tv_ff;
   logic signed [dpss_pkg::POS_W-1:0]   rsp_tp_ff;

   dpss_pkg::axis_state_type            cur;
   dpss_pkg::axis_state_type            nxt;
   logic                                axis_hit;
   logic                                step_acc;
   logic                                step_tv;
   logic signed [dpss_pkg::POS_W-1:0]   step_tp;
   logic                                fire;

   assign fire         = in_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || fire;
   assign csr_ch.ready = 1'b1;

   // axis below both the programmed count and the built-in axis count
   assign axis_hit = (in_axis_ff < axis_count_ff) && (32'(in_axis_ff) < NUM_AXES);

   always_comb begin
      cur = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (32'(in_axis_ff) == i) begin
            cur = axis_ff[i];
         end
      end
   end

   dpss_axis_step u_step (
      .cur             (cur),
      .axis_hit        (axis_hit),
      .operation       (in_op_ff),
      .status_word     (in_sw_ff),
      .actual_position (in_pos_ff),
      .nxt             (nxt),
      .accepted        (step_acc),
      .target_valid    (step_tv),
      .target_position (step_tp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_count_ff <= '0;
      end else if (csr_ch.valid) begin
         axis_count_ff <= csr_ch.axis_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_axis_ff <= req_ch.axis;
         in_op_ff   <= req_ch.operation;
         in_sw_ff   <= req_ch.status_word;
         in_pos_ff  <= req_ch.actual_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            axis_ff[i] <= '0;
         end
      end else if (fire && step_acc) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            if (32'(in_axis_ff) == i) begin
               axis_ff[i] <= nxt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_acc_ff    <= step_acc;
         rsp_ctrl_ff   <= nxt.ctrl;
         rsp_state_ff  <= nxt.state;
         rsp_report_ff <= nxt.report;
         rsp_tv_ff     <= step_tv;
         rsp_tp_ff     <= step_tp;
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.accepted        = rsp_acc_ff;
   assign rsp_ch.control_word    = dpss_pkg::CW_W'(rsp_ctrl_ff);
   assign rsp_ch.drive_state     = rsp_state_ff;
   assign rsp_ch.axis_report     = rsp_report_ff;
   assign rsp_ch.target_valid    = rsp_tv_ff;
   assign rsp_ch.target_position = rsp_tp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_needs_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(in_vld_ff))
      else $error("response appeared without a held request");

   a_target_only_early: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_tv_ff) |->
         (rsp_acc_ff && (rsp_state_ff == dpss_pkg::ST_NOT_READY ||
                         rsp_state_ff == dpss_pkg::ST_SWON_DIS)))
      else $error("target echoed outside power-up start");

   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_acc_ff) |-> (!rsp_tv_ff && rsp_tp_ff == '0))
      else $error("ignored request produced a target");

   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_vld_ff)
      else $error("processed request lost");
`endif

endmodule

`default_nettype wire

// ----- sv/dpss_axis_step.sv -----
// ----------------------------------------------------------------------------
// Drive power state sequencer axis step
// Next state, control word and target echo for one axis and one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpss_axis_step (
   input  dpss_pkg::axis_state_type             cur,
   input  logic                                 axis_hit,
   input  logic [dpss_pkg::OP_W-1:0]            operation,
   input  logic [dpss_pkg::STATUS_W-1:0]        status_word,
   input  logic signed [dpss_pkg::POS_W-1:0]    actual_position,
   output dpss_pkg::axis_state_type             nxt,
   output logic                                 accepted,
   output logic                                 target_valid,
   output logic signed [dpss_pkg::POS_W-1:0]    target_position
);

   logic [7:0] sw_lo;
   logic [7:0] m4f;

   assign sw_lo = status_word[7:0];
   assign m4f   = sw_lo & dpss_pkg::MASK_4F;

   always_comb begin
      nxt             = cur;
      accepted        = 1'b0;
      target_valid    = 1'b0;
      target_position = '0;
      if (axis_hit) begin
         accepted = 1'b1;
         case (dpss_pkg::op_type'(operation))
            dpss_pkg::OP_STATUS: begin
               if (cur.cmd == dpss_pkg::CMD_START) begin
                  if (status_word[dpss_pkg::SW_BIT_FAULT]) begin
                     nxt.ctrl   = dpss_pkg::CW_FAULT_RESET;
                     nxt.report = dpss_pkg::REPORT_FAULT;
                  end else begin
                     unique case (cur.state)
                        dpss_pkg::ST_NOT_READY: begin
                           // echo position so the drive holds still on enable
                           target_valid    = 1'b1;
                           target_position = actual_position;
                           if (m4f == dpss_pkg::SW_NONE ||
                               m4f == dpss_pkg::SW_ON_DISABLED) begin
                              nxt.ctrl  = dpss_pkg::CW_SHUTDOWN;
                              nxt.state = dpss_pkg::ST_SWON_DIS;
                           end else if (status_word[dpss_pkg::SW_BIT_READY]) begin
                              nxt.state = dpss_pkg::ST_SWON_DIS;
                           end
                        end
                        dpss_pkg::ST_SWON_DIS: begin
                           if (m4f == dpss_pkg::SW_ON_DISABLED) begin
                              nxt.ctrl  = dpss_pkg::CW_SHUTDOWN;
                              nxt.state = dpss_pkg::ST_READY;
                           end else if (m4f == dpss_pkg::SW_RDY_ONLY) begin
                              nxt.state = dpss_pkg::ST_READY;
                           end else if ((sw_lo & dpss_pkg::MASK_69) ==
                                        dpss_pkg::SW_READY_QS) begin
                              nxt.state = dpss_pkg::ST_SWITCHED_ON;
                           end
                        end
                        dpss_pkg::ST_READY: begin
                           if ((sw_lo & dpss_pkg::MASK_6F) == dpss_pkg::SW_READY_QS) begin
                              nxt.ctrl  = dpss_pkg::CW_SWITCH_ON;
                              nxt.state = dpss_pkg::ST_SWITCHED_ON;
                           end
                        end
                        dpss_pkg::ST_SWITCHED_ON: begin
                           if ((sw_lo & dpss_pkg::MASK_6F) == dpss_pkg::SW_ON_QS) begin
                              nxt.ctrl  = dpss_pkg::CW_ENABLE_OP;
                              nxt.state = dpss_pkg::ST_OP_ENABLED;
                           end
                        end
                        dpss_pkg::ST_OP_ENABLED: begin
                           if ((sw_lo & dpss_pkg::MASK_7F) == dpss_pkg::SW_OPERATING) begin
                              nxt.report = dpss_pkg::REPORT_OPERATING;
                           end
                        end
                        dpss_pkg::ST_FAULT_REACTION: begin
                           nxt.ctrl  = dpss_pkg::CW_FAULT_RESET;
                           nxt.state = dpss_pkg::ST_NOT_READY;
                        end
                        default: begin
                           // malfunction: hold until a stop
                        end
                     endcase
                  end
               end else if (cur.cmd == dpss_pkg::CMD_STOP) begin
                  nxt.ctrl   = dpss_pkg::CW_SHUTDOWN;
                  nxt.state  = dpss_pkg::ST_NOT_READY;
                  nxt.report = dpss_pkg::REPORT_IDLE;
                  nxt.cmd    = dpss_pkg::CMD_NONE;
               end
            end
            dpss_pkg::OP_START: nxt.cmd = dpss_pkg::CMD_START;
            dpss_pkg::OP_STOP:  nxt.cmd = dpss_pkg::CMD_STOP;
            default:            accepted = 1'b0;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Drive power state sequencer testbench
// Drives status, start and stop requests through the per-axis power-up
// walk and checks every response against an in-bench prediction of the
// axis state, control word, report and target echo, under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dpss_pkg::*;

   localparam int AXIS_SLOTS = 6;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 180;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [AXIS_W-1:0]          axis;
      logic [OP_W-1:0]            operation;
      logic [STATUS_W-1:0]        status_word;
      logic signed [POS_W-1:0]    actual_position;
   } req_item_t;

   typedef struct packed {
      logic                       accepted;
      logic [CW_W-1:0]            control_word;
      logic [2:0]                 drive_state;
      logic [1:0]                 axis_report;
      logic                       target_valid;
      logic signed [POS_W-1:0]    target_position;
   } rsp_item_t;

   logic clock;
   logic reset;

   dpss_req_if req_ch ();
   dpss_rsp_if rsp_ch ();
   dpss_csr_if csr_ch ();

   drive_power_state_sequencer #(.NUM_AXES(AXIS_SLOTS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predicted per-axis state
   drive_state_type   axis_state [AXIS_SLOTS];
   cmd_type           axis_cmd   [AXIS_SLOTS];
   logic [CTRL_W-1:0] axis_ctrl  [AXIS_SLOTS];
   report_type        axis_rpt   [AXIS_SLOTS];
   logic [COUNT_W-1:0] axis_count_reg;

   req_item_t  pending_reqs [$];
   rsp_item_t  expected_rsps [$];

   int unsigned issued_count;
   int unsigned taken_count;
   int unsigned live_count;
   int unsigned gen_axes;
   int unsigned fail_count;
   int unsigned print_count;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   bit          req_taken;
   bit          csr_written;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic rsp_item_t predict_response(input req_item_t r);
      rsp_item_t    e;
      int unsigned  live;
      int unsigned  a;
      logic [7:0]   sw;
      logic [7:0]   m4f;
      e = '0;
      live = (axis_count_reg > AXIS_SLOTS) ? AXIS_SLOTS : axis_count_reg;
      a = r.axis;
      sw = r.status_word[7:0];
      m4f = sw & MASK_4F;
      if (a < live && r.operation != OP_UNUSED) begin
         e.accepted = 1'b1;
         case (r.operation)
            OP_START: axis_cmd[a] = CMD_START;
            OP_STOP:  axis_cmd[a] = CMD_STOP;
            default: begin
               if (axis_cmd[a] == CMD_START) begin
                  if (r.status_word[SW_BIT_FAULT]) begin
                     axis_ctrl[a] = CW_FAULT_RESET;
                     axis_rpt[a] = REPORT_FAULT;
                  end else begin
                     case (axis_state[a])
                        ST_NOT_READY: begin
                           // echo actual position as target while not ready
                           e.target_valid = 1'b1;
                           e.target_position = r.actual_position;
                           if (m4f == SW_NONE || m4f == SW_ON_DISABLED) begin
                              axis_ctrl[a] = CW_SHUTDOWN;
                              axis_state[a] = ST_SWON_DIS;
                           end else if (r.status_word[SW_BIT_READY]) begin
                              axis_state[a] = ST_SWON_DIS;
                           end
                        end
                        ST_SWON_DIS: begin
                           if (m4f == SW_ON_DISABLED) begin
                              axis_ctrl[a] = CW_SHUTDOWN;
                              axis_state[a] = ST_READY;
                           end else if (m4f == SW_RDY_ONLY) begin
                              axis_state[a] = ST_READY;
                           end else if ((sw & MASK_69) == SW_READY_QS) begin
                              axis_state[a] = ST_SWITCHED_ON;
                           end
                        end
                        ST_READY: begin
                           if ((sw & MASK_6F) == SW_READY_QS) begin
                              axis_ctrl[a] = CW_SWITCH_ON;
                              axis_state[a] = ST_SWITCHED_ON;
                           end
                        end
                        ST_SWITCHED_ON: begin
                           if ((sw & MASK_6F) == SW_ON_QS) begin
                              axis_ctrl[a] = CW_ENABLE_OP;
                              axis_state[a] = ST_OP_ENABLED;
                           end
                        end
                        ST_OP_ENABLED: begin
                           if ((sw & MASK_7F) == SW_OPERATING)
                              axis_rpt[a] = REPORT_OPERATING;
                        end
                        ST_FAULT_REACTION: begin
                           axis_ctrl[a] = CW_FAULT_RESET;
                           axis_state[a] = ST_NOT_READY;
                        end
                        default: ;
                     endcase
                  end
               end else if (axis_cmd[a] == CMD_STOP) begin
                  axis_ctrl[a] = CW_SHUTDOWN;
                  axis_state[a] = ST_NOT_READY;
                  axis_rpt[a] = REPORT_IDLE;
                  axis_cmd[a] = CMD_NONE;
               end
            end
         endcase
      end
      if (a < AXIS_SLOTS) begin
         e.control_word = axis_ctrl[a];
         e.drive_state = axis_state[a];
         e.axis_report = axis_rpt[a];
      end
      return e;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (print_count < 40) begin
            print_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      end
   endtask

   // accept requests, predict, and check responses
   always @(posedge clock) begin
      req_item_t r;
      rsp_item_t e;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            r.axis = req_ch.axis;
            r.operation = req_ch.operation;
            r.status_word = req_ch.status_word;
            r.actual_position = req_ch.actual_position;
            expected_rsps.push_back(predict_response(r));
            taken_count++;
            req_taken = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (print_count < 40) begin
                  print_count++;
                  $display("%0t: response with none expected, actual cw %h state %0d",
                           $time, rsp_ch.control_word, rsp_ch.drive_state);
               end
            end else begin
               e = expected_rsps.pop_front();
               check_field("accepted", e.accepted, rsp_ch.accepted);
               check_field("control_word", e.control_word, rsp_ch.control_word);
               check_field("drive_state", e.drive_state, rsp_ch.drive_state);
               check_field("axis_report", e.axis_report, rsp_ch.axis_report);
               check_field("target_valid", e.target_valid, rsp_ch.target_valid);
               check_field("target_position", e.target_position,
                           rsp_ch.target_position);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            axis_count_reg = csr_ch.axis_count;
            csr_written = 1'b1;
         end
      end
   end

   // drive requests and response ready on the falling edge
   always @(negedge clock) begin
      req_item_t nxt;
      if (!req_ch.valid || req_taken) begin
         if (!reset && pending_reqs.size() != 0
             && $urandom_range(99) >= sender_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.axis <= nxt.axis;
            req_ch.operation <= nxt.operation;
            req_ch.status_word <= nxt.status_word;
            req_ch.actual_position <= nxt.actual_position;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic push_req(input logic [AXIS_W-1:0] a, input logic [OP_W-1:0] op,
                           input logic [STATUS_W-1:0] sw, input logic [POS_W-1:0] pos);
      req_item_t r;
      r.axis = a;
      r.operation = op;
      r.status_word = sw;
      r.actual_position = pos;
      pending_reqs.push_back(r);
      issued_count++;
      if (a < gen_axes && op != OP_UNUSED)
         live_count++;
   endtask

   task automatic write_axis_count(input logic [COUNT_W-1:0] n);
      @(negedge clock);
      csr_written = 1'b0;
      csr_ch.axis_count <= n;
      csr_ch.valid <= 1'b1;
      do @(negedge clock); while (!csr_written);
      csr_ch.valid <= 1'b0;
      gen_axes = (n > AXIS_SLOTS) ? AXIS_SLOTS : n;
   endtask

   task automatic drain_requests();
      while (taken_count != issued_count || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one power-up walk on an axis, usually started and stopped, with faults and noise mixed in
   task automatic queue_power_up(input logic [AXIS_W-1:0] a);
      logic [7:0]  walk [5];
      logic [15:0] rnd;
      logic [15:0] sw;
      int unsigned i;
      int unsigned r;
      int unsigned extra;
      case ($urandom_range(2))
         0: walk[0] = SW_NONE;
         1: walk[0] = SW_ON_DISABLED;
         default: walk[0] = SW_RDY_ONLY;
      endcase
      case ($urandom_range(2))
         0: walk[1] = SW_READY_QS;
         1: walk[1] = SW_ON_DISABLED;
         default: walk[1] = SW_ON_QS;
      endcase
      walk[2] = SW_READY_QS;
      walk[3] = SW_ON_QS;
      walk[4] = SW_OPERATING;
      extra = $urandom_range(2);
      if ($urandom_range(9) != 0)
         push_req(a, OP_START, $urandom, $urandom);
      for (i = 0; i < 5 + extra; i++) begin
         rnd = $urandom;
         r = $urandom_range(99);
         if (r < 6)
            sw = rnd | 16'h0008;
         else if (r < 14)
            sw = rnd;
         else
            sw = (rnd & 16'hFF80) | walk[(i < 5) ? i : 4];
         push_req(a, OP_STATUS, sw, $urandom);
      end
      if ($urandom_range(9) < 7) begin
         push_req(a, OP_STOP, $urandom, $urandom);
         push_req(a, OP_STATUS, $urandom, $urandom);
      end
   endtask

   task automatic queue_phase();
      int unsigned n;
      live_count = 0;
      n = 0;
      while ((gen_axes != 0) ? (live_count < PHASE_ITEMS) : (n < 40)) begin
         if (gen_axes != 0 && $urandom_range(99) < 70)
            queue_power_up($urandom_range(gen_axes - 1));
         else
            push_req($urandom_range(7), $urandom_range(3), $urandom, $urandom);
         n++;
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_count [8];
      int unsigned p;
      phase_count = '{3'd6, 3'd7, 3'd3, 3'd0, 3'd1, 3'd6, 3'd5, 3'd6};
      for (int i = 0; i < AXIS_SLOTS; i++) begin
         axis_state[i] = ST_NOT_READY;
         axis_cmd[i] = CMD_NONE;
         axis_ctrl[i] = '0;
         axis_rpt[i] = REPORT_IDLE;
      end
      axis_count_reg = '0;
      issued_count = 0;
      taken_count = 0;
      live_count = 0;
      gen_axes = 0;
      fail_count = 0;
      print_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      req_taken = 1'b0;
      csr_written = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.axis = '0;
      req_ch.operation = '0;
      req_ch.status_word = '0;
      req_ch.actual_position = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.axis_count = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed walk through the power-up states
      write_axis_count(3'd6);
      push_req(0, OP_STATUS, 16'hFFFF, 32'h8000_0000);
      push_req(0, OP_START, 16'h0000, 32'h0000_0000);
      push_req(0, OP_STATUS, 16'h0008, 32'h1234_5678);
      push_req(0, OP_STATUS, 16'h0040, 32'h7FFF_FFFF);
      push_req(0, OP_STATUS, 16'h0000, 32'h0000_0001);
      push_req(0, OP_STATUS, 16'h0021, 32'h0000_0002);
      push_req(0, OP_STATUS, 16'h0020, 32'h0000_0003);
      push_req(0, OP_STATUS, 16'h0021, 32'h0000_0004);
      push_req(0, OP_STATUS, 16'h0023, 32'h0000_0005);
      push_req(0, OP_STATUS, 16'h0037, 32'h0000_0006);
      push_req(0, OP_STATUS, 16'hFFB7, 32'h0000_0007);
      push_req(0, OP_STOP, 16'h0000, 32'h0000_0000);
      push_req(0, OP_STATUS, 16'h0040, 32'h8000_0000);
      push_req(0, OP_STATUS, 16'h0040, 32'h8000_0000);
      push_req(1, OP_START, 16'h0000, 32'h0000_0000);
      push_req(1, OP_STATUS, 16'h0001, 32'h0000_0000);
      push_req(1, OP_STATUS, 16'h0023, 32'hFFFF_FFFF);
      push_req(1, OP_STATUS, 16'h0009, 32'h0000_0000);
      push_req(2, OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      push_req(6, OP_STATUS, 16'h0040, 32'h0000_0001);
      push_req(7, OP_START, 16'h0000, 32'h0000_0000);
      push_req(5, OP_START, 16'h0000, 32'h0000_0000);
      push_req(5, OP_STATUS, 16'hFFFF, 32'h0000_0000);
      push_req(5, OP_STATUS, 16'hFFF7, 32'hFFFF_FFFF);
      drain_requests();

      // random phases, cycling the idle modes across axis counts
      for (p = 0; p < 8; p++) begin
         write_axis_count(phase_count[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         endcase
         queue_phase();
         drain_requests();
      end

      repeat (20) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         fail_count++;
         $display("%0t: %0d responses never arrived", $time, expected_rsps.size());
      end
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- drive_power_state_sequencer.f -----
sv/dpss_pkg.sv
sv/dpss_if.sv
sv/dpss_axis_step.sv
sv/drive_power_state_sequencer.sv
dv/tb_top.sv
